// ===== rtl/core/ladsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear ADSR envelope package
// Types, register indexes, request codes and reset values for the envelope.
// ----------------------------------------------------------------------------
package ladsr_pkg;

	localparam int unsigned LevelW  = 24;
	localparam int unsigned SampleW = 24;
	localparam int unsigned AStepW  = 23;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_NOTE_ON  = 2'd1,
		REQ_NOTE_OFF = 2'd2,
		REQ_STOP     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_ATTACK_STEP   = 3'd0,
		CFG_DECAY_STEP    = 3'd1,
		CFG_RELEASE_STEP  = 3'd2,
		CFG_PEAK_LEVEL    = 3'd3,
		CFG_SUSTAIN_LEVEL = 3'd4,
		CFG_RELEASE_FLOOR = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_ATTACK  = 5'b00010,
		ST_DECAY   = 5'b00100,
		ST_SUSTAIN = 5'b01000,
		ST_RELEASE = 5'b10000
	} stage_t;

	localparam logic [AStepW-1:0]         AttackStepRst   = 23'd12691;
	localparam logic signed [LevelW-1:0]  DecayStepRst    = -24'sd671;
	localparam logic signed [LevelW-1:0]  ReleaseStepRst  = -24'sd166;
	localparam logic [LevelW-1:0]         PeakLevelRst    = 24'd8388608;
	localparam logic [LevelW-1:0]         SustainLevelRst = 24'd1677722;
	localparam logic [LevelW-1:0]         ReleaseFloorRst = 24'd0;

	localparam logic [LevelW-1:0]  LevelMax  = 24'hFFFFFF;
	localparam logic [SampleW-1:0] SampleMax = 24'h7FFFFF;
	localparam logic [SampleW-1:0] SampleMin = 24'h800000;

endpackage

// ===== rtl/core/linear_adsr_envelope_unit.sv =====
// ----------------------------------------------------------------------------
// Linear ADSR envelope unit
// Linear attack/decay/sustain/release envelope applied to a 24-bit stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tuser carries the request (tick, note on, note off,
//   stop), s_tdata the signed sample. Ticks give one result each on m_*;
//   control transactions only change the envelope stage and give none.
//   Output m_tdata carries sample_out and level, m_tuser the idle flag.
//   Configuration channel cfg_*: index and data, always ready; write only
//   while the block holds no transaction in flight.
//   Path: a result goes through the input register, the level update
//   register and the product register before it appears on m_*.
//   Throughput: one transaction per cycle while m_tready allows, set by the
//   combinational level update; the multiply sits in its own stage.
//   Reset: asynchronous, clears the pipeline, the stage goes idle at level
//   zero and the step and level registers take their defaults.
//   Stall: a held result keeps its register; the stages behind it keep
//   accepting until each is full, then s_tready drops.
// ----------------------------------------------------------------------------
module linear_adsr_envelope_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] sample_in
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [23:0] sample_out, [47:24] level
	output logic        m_tuser,   // [0] idle
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic [ladsr_pkg::AStepW-1:0]        attack_step_q;
	logic signed [ladsr_pkg::LevelW-1:0] decay_step_q;
	logic signed [ladsr_pkg::LevelW-1:0] release_step_q;
	logic [ladsr_pkg::LevelW-1:0]        peak_level_q;
	logic [ladsr_pkg::LevelW-1:0]        sustain_level_q;
	logic [ladsr_pkg::LevelW-1:0]        release_floor_q;

	ladsr_pkg::stage_t             stage_q;
	ladsr_pkg::stage_t             stage_d;
	logic [ladsr_pkg::LevelW-1:0]  level_q;
	logic [ladsr_pkg::LevelW-1:0]  level_d;

	logic                                 valid_s1;
	ladsr_pkg::req_t                      req_s1;
	logic signed [ladsr_pkg::SampleW-1:0] sample_s1;

	logic                                 valid_s2;
	logic signed [ladsr_pkg::SampleW-1:0] sample_s2;
	logic [ladsr_pkg::LevelW-1:0]         level_s2;
	logic                                 idle_s2;

	logic                                 out_valid_q;
	logic [ladsr_pkg::SampleW-1:0]        out_sample_q;
	logic [ladsr_pkg::LevelW-1:0]         out_level_q;
	logic                                 out_idle_q;

	logic                adv_out;
	logic                adv_s2;
	logic                take_s1;
	logic signed [25:0]  step_ext;
	logic signed [25:0]  level_sum;
	logic [ladsr_pkg::LevelW-1:0] level_sat;
	logic signed [48:0]  product;
	logic signed [25:0]  prod_shr;
	logic [ladsr_pkg::SampleW-1:0] scaled;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_step_q   <= ladsr_pkg::AttackStepRst;
			decay_step_q    <= ladsr_pkg::DecayStepRst;
			release_step_q  <= ladsr_pkg::ReleaseStepRst;
			peak_level_q    <= ladsr_pkg::PeakLevelRst;
			sustain_level_q <= ladsr_pkg::SustainLevelRst;
			release_floor_q <= ladsr_pkg::ReleaseFloorRst;
		end else if (cfg_valid) begin
			unique case (ladsr_pkg::cfg_idx_t'(cfg_index))
				ladsr_pkg::CFG_ATTACK_STEP:   attack_step_q   <= cfg_data[22:0];
				ladsr_pkg::CFG_DECAY_STEP:    decay_step_q    <= cfg_data;
				ladsr_pkg::CFG_RELEASE_STEP:  release_step_q  <= cfg_data;
				ladsr_pkg::CFG_PEAK_LEVEL:    peak_level_q    <= cfg_data;
				ladsr_pkg::CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data;
				ladsr_pkg::CFG_RELEASE_FLOOR: release_floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_out  = !out_valid_q || m_tready;
	assign adv_s2   = !valid_s2 || adv_out;
	assign s_tready = !valid_s1 || adv_s2;
	assign take_s1  = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1    <= ladsr_pkg::req_t'(s_tuser);
			sample_s1 <= s_tdata;
		end
	end

	always_comb begin
		unique case (stage_q)
			ladsr_pkg::ST_ATTACK:  step_ext = $signed({3'b000, attack_step_q});
			ladsr_pkg::ST_DECAY:   step_ext = 26'(decay_step_q);
			ladsr_pkg::ST_RELEASE: step_ext = 26'(release_step_q);
			default:               step_ext = '0;
		endcase
		level_sum = $signed({2'b00, level_q}) + step_ext;
		if (level_sum[25]) begin
			level_sat = '0;
		end else if (level_sum[24]) begin
			level_sat = ladsr_pkg::LevelMax;
		end else begin
			level_sat = level_sum[23:0];
		end
	end

	always_comb begin
		stage_d = stage_q;
		level_d = level_q;
		unique case (req_s1)
			ladsr_pkg::REQ_NOTE_ON:  stage_d = ladsr_pkg::ST_ATTACK;
			ladsr_pkg::REQ_NOTE_OFF: stage_d = ladsr_pkg::ST_RELEASE;
			ladsr_pkg::REQ_STOP:     stage_d = ladsr_pkg::ST_IDLE;
			default: begin
				unique case (stage_q)
					ladsr_pkg::ST_ATTACK: begin
						level_d = level_sat;
						if (level_sat >= peak_level_q) begin
							level_d = peak_level_q;
							stage_d = ladsr_pkg::ST_DECAY;
						end
					end
					ladsr_pkg::ST_DECAY: begin
						level_d = level_sat;
						if (level_sat <= sustain_level_q) begin
							level_d = sustain_level_q;
							stage_d = ladsr_pkg::ST_SUSTAIN;
						end
					end
					ladsr_pkg::ST_SUSTAIN: ;
					ladsr_pkg::ST_RELEASE: begin
						level_d = level_sat;
						if (level_sat <= release_floor_q) begin
							level_d = '0;
							stage_d = ladsr_pkg::ST_IDLE;
						end
					end
					default: stage_d = ladsr_pkg::ST_IDLE;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= ladsr_pkg::ST_IDLE;
			level_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				stage_q <= stage_d;
				level_q <= level_d;
			end
			if (adv_s2) begin
				valid_s2 <= take_s1 && (req_s1 == ladsr_pkg::REQ_TICK);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			sample_s2 <= sample_s1;
			level_s2  <= level_d;
			idle_s2   <= (stage_d == ladsr_pkg::ST_IDLE);
		end
	end

	assign product  = sample_s2 * $signed({1'b0, level_s2});
	assign prod_shr = product[48:23];

	always_comb begin
		if (idle_s2) begin
			scaled = '0;
		end else if ((prod_shr[25:23] == 3'b000) || (prod_shr[25:23] == 3'b111)) begin
			scaled = prod_shr[23:0];
		end else if (prod_shr[25]) begin
			scaled = ladsr_pkg::SampleMin;
		end else begin
			scaled = ladsr_pkg::SampleMax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			out_sample_q <= scaled;
			out_level_q  <= level_s2;
			out_idle_q   <= idle_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_level_q, out_sample_q};
	assign m_tuser  = out_idle_q;

`ifndef ASSERT_OFF
	a_ctrl_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && req_s1 != ladsr_pkg::REQ_TICK) |=> !valid_s2)
		else $error("control transaction produced a result");

	a_sustain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && req_s1 == ladsr_pkg::REQ_TICK && stage_q == ladsr_pkg::ST_SUSTAIN)
		|=> (level_q == $past(level_q)))
		else $error("sustain tick changed the level");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[23:0] == 24'd0))
		else $error("idle result with non-zero sample");

	a_release_end: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && req_s1 == ladsr_pkg::REQ_TICK && stage_q == ladsr_pkg::ST_RELEASE
		&& stage_d == ladsr_pkg::ST_IDLE) |=> (level_q == '0))
		else $error("release ended with non-zero level");
`endif

endmodule

// ===== sim/linear_adsr_envelope_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Linear ADSR envelope unit testbench
// Starts with a short table of directed requests and register writes, then
// runs random notes in phases, each after random writes to some registers.
// Every tick result is checked against a local envelope predictor or, for
// typed table rows, their expected values. The input side idles in bursts
// and the output side stalls on its own pattern.
module linear_adsr_envelope_unit_tb;

	import ladsr_pkg::*;

	localparam int unsigned RunLimit    = 600000;
	localparam int unsigned RandomItems = 1900;
	localparam int unsigned PipeSlack   = 8;

	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_PERIODIC,
		RX_COIN,
		RX_BURSTY
	} rx_mode_t;

	typedef struct packed {
		logic [23:0] sample_out;
		logic [23:0] level;
		logic        idle;
	} env_result_t;

	typedef struct packed {
		logic        is_write;
		logic [2:0]  reg_idx;
		logic [23:0] reg_data;
		req_t        req;
		logic [23:0] sample;
		logic        typed;
		env_result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	env_result_t pending_results[$];
	stim_row_t   stim_table[$];

	int unsigned errors       = 0;
	int unsigned items_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned reg_writes   = 0;
	int unsigned burst_left   = 0;
	int unsigned cycles       = 0;
	int unsigned rx_tick      = 0;
	int unsigned rx_hold      = 0;
	rx_mode_t    rx_mode      = RX_OPEN;

	stage_t env_stage;
	longint env_level;
	longint attack_step;
	longint decay_step;
	longint release_step;
	longint peak_level;
	longint sustain_level;
	longint release_floor;

	linear_adsr_envelope_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_envelope();
		env_stage     = ST_IDLE;
		env_level     = 0;
		attack_step   = longint'(AttackStepRst);
		decay_step    = longint'(DecayStepRst);
		release_step  = longint'(ReleaseStepRst);
		peak_level    = longint'(PeakLevelRst);
		sustain_level = longint'(SustainLevelRst);
		release_floor = longint'(ReleaseFloorRst);
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [23:0] d);
		case (idx)
			CFG_ATTACK_STEP:   attack_step   = longint'(d[22:0]);
			CFG_DECAY_STEP:    decay_step    = longint'($signed(d));
			CFG_RELEASE_STEP:  release_step  = longint'($signed(d));
			CFG_PEAK_LEVEL:    peak_level    = longint'(d);
			CFG_SUSTAIN_LEVEL: sustain_level = longint'(d);
			CFG_RELEASE_FLOOR: release_floor = longint'(d);
			default: ;
		endcase
	endfunction

	function automatic longint clamp_level(longint v);
		if (v < 0)
			return 0;
		if (v > longint'(LevelMax))
			return longint'(LevelMax);
		return v;
	endfunction

	function automatic logic [23:0] scale_sample(logic [23:0] smp, longint lvl);
		longint p;
		p = longint'($signed(smp)) * lvl;
		p = p >>> 23;
		if (p > 8388607)
			p = 8388607;
		if (p < -8388608)
			p = -8388608;
		return p[23:0];
	endfunction

	function automatic bit envelope_step(req_t r, logic [23:0] smp, output env_result_t res);
		res = '0;
		case (r)
			REQ_NOTE_ON: begin
				env_stage = ST_ATTACK;
				return 1'b0;
			end
			REQ_NOTE_OFF: begin
				env_stage = ST_RELEASE;
				return 1'b0;
			end
			REQ_STOP: begin
				env_stage = ST_IDLE;
				return 1'b0;
			end
			default: ;
		endcase
		case (env_stage)
			ST_ATTACK: begin
				env_level = clamp_level(env_level + attack_step);
				if (env_level >= peak_level) begin
					env_level = peak_level;
					env_stage = ST_DECAY;
				end
			end
			ST_DECAY: begin
				env_level = clamp_level(env_level + decay_step);
				if (env_level <= sustain_level) begin
					env_level = sustain_level;
					env_stage = ST_SUSTAIN;
				end
			end
			ST_SUSTAIN: ;
			ST_RELEASE: begin
				env_level = clamp_level(env_level + release_step);
				if (env_level <= release_floor) begin
					env_level = 0;
					env_stage = ST_IDLE;
				end
			end
			default: env_stage = ST_IDLE;
		endcase
		res.idle       = (env_stage == ST_IDLE);
		res.level      = env_level[23:0];
		res.sample_out = res.idle ? 24'd0 : scale_sample(smp, env_level);
		return 1'b1;
	endfunction

	function automatic logic [22:0] rand_mag();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return 23'($urandom_range(1, (1 << $urandom_range(8, 23)) - 1));
		endcase
	endfunction

	function automatic logic [23:0] rand_fall_step();
		case ($urandom_range(0, 19))
			0: return 24'h800000;
			1: return '0;
			2, 3: return {1'b0, rand_mag()};
			default: return -{1'b0, rand_mag()};
		endcase
	endfunction

	function automatic logic [23:0] rand_level();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 24'h800000;
			2: return '1;
			3: return 24'($urandom);
			default: return 24'($urandom_range(0, 8388608));
		endcase
	endfunction

	function automatic logic [23:0] reg_value(logic [2:0] idx);
		case (idx)
			CFG_ATTACK_STEP: return {1'($urandom_range(0, 1)), rand_mag()};
			CFG_DECAY_STEP, CFG_RELEASE_STEP: return rand_fall_step();
			CFG_PEAK_LEVEL, CFG_SUSTAIN_LEVEL, CFG_RELEASE_FLOOR: return rand_level();
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic note_mismatch(string what, logic [47:0] got, logic [47:0] want);
		$display("%s mismatch at result %0d: got %0h, expected %0h",
			what, results_seen, got, want);
		errors++;
	endtask

	task automatic add_item(req_t r, logic [23:0] smp);
		stim_row_t row;
		row        = '0;
		row.req    = r;
		row.sample = smp;
		stim_table.insert(stim_table.size(), row);
	endtask

	task automatic add_typed(logic [23:0] smp, logic [23:0] so, logic [23:0] lvl, logic idl);
		stim_row_t row;
		row        = '0;
		row.req    = REQ_TICK;
		row.sample = smp;
		row.typed  = 1'b1;
		row.want   = '{sample_out: so, level: lvl, idle: idl};
		stim_table.insert(stim_table.size(), row);
	endtask

	task automatic add_write(logic [2:0] idx, logic [23:0] d);
		stim_row_t row;
		row          = '0;
		row.is_write = 1'b1;
		row.reg_idx  = idx;
		row.reg_data = d;
		stim_table.insert(stim_table.size(), row);
	endtask

	task automatic send_item(req_t r, logic [23:0] smp, logic typed, env_result_t want);
		env_result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser  <= r;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (envelope_step(r, smp, predicted))
			pending_results.insert(pending_results.size(), typed ? want : predicted);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
	endtask

	task automatic send_tick();
		send_item(REQ_TICK, 24'($urandom), 1'b0, '0);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, d);
		reg_writes++;
	endtask

	// hold input until every tick result is out, then let control transactions clear
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PipeSlack) @(posedge clk);
	endtask

	task automatic reconfigure();
		logic [2:0] idx;
		for (int unsigned i = 0; i < 8; i++) begin
			idx = 3'(i);
			if ($urandom_range(0, (idx == CFG_SPARE_LO || idx == CFG_SPARE_HI) ? 7 : 1) == 0)
				write_reg(idx, reg_value(idx));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic play_phase(int unsigned n);
		int unsigned start;
		start = items_sent;
		while (items_sent - start < n) begin
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 4))
					send_item(req_t'($urandom_range(0, 3)), 24'($urandom), 1'b0, '0);
			end else begin
				send_item(REQ_NOTE_ON, 24'($urandom), 1'b0, '0);
				repeat ($urandom_range(0, 40)) send_tick();
				if ($urandom_range(0, 4) != 0) begin
					send_item(REQ_NOTE_OFF, 24'($urandom), 1'b0, '0);
					repeat ($urandom_range(0, 40)) send_tick();
				end else begin
					send_item(REQ_STOP, 24'($urandom), 1'b0, '0);
					repeat ($urandom_range(0, 3)) send_tick();
				end
			end
		end
	endtask

	always @(posedge clk) begin : drive_ready
		rx_tick++;
		if (rx_tick % 300 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:     m_tready <= 1'b1;
				RX_PERIODIC: m_tready <= (rx_tick % 4) != 3;
				RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 15) == 0) begin
						rx_hold = $urandom_range(4, 20);
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		env_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected transaction", m_tdata, '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[23:0] !== want.sample_out)
					note_mismatch("sample_out", 48'(m_tdata[23:0]), 48'(want.sample_out));
				if (m_tdata[47:24] !== want.level)
					note_mismatch("level", 48'(m_tdata[47:24]), 48'(want.level));
				if (m_tuser !== want.idle)
					note_mismatch("idle", 48'(m_tuser), 48'(want.idle));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > RunLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t   row;
		int unsigned random_start;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= REQ_TICK;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ATTACK_STEP;
		cfg_data  <= '0;
		reset_envelope();

		add_typed(24'h7FFFFF, 24'h000000, 24'h000000, 1'b1);
		add_item(REQ_NOTE_OFF, 24'h000000);
		add_typed(24'h800000, 24'h000000, 24'h000000, 1'b1);
		add_item(REQ_NOTE_ON, 24'hFFFFFF);
		add_item(REQ_TICK, 24'h7FFFFF);
		add_write(CFG_ATTACK_STEP, 24'hFFFFFF);
		add_typed(24'h800000, 24'h800000, 24'h800000, 1'b0);
		add_write(CFG_DECAY_STEP, 24'h800000);
		add_item(REQ_TICK, 24'h7FFFFF);
		add_write(CFG_SUSTAIN_LEVEL, 24'hFFFFFF);
		add_item(REQ_TICK, 24'h400000);
		add_write(CFG_RELEASE_STEP, 24'h000000);
		add_item(REQ_NOTE_OFF, 24'h123456);
		add_item(REQ_TICK, 24'h000000);
		add_write(CFG_RELEASE_FLOOR, 24'hFFFFFF);
		add_typed(24'h7FFFFF, 24'h000000, 24'h000000, 1'b1);
		add_write(CFG_PEAK_LEVEL, 24'hFFFFFF);
		add_item(REQ_NOTE_ON, 24'h000000);
		add_item(REQ_TICK, 24'h555555);
		add_item(REQ_TICK, 24'hAAAAAA);
		add_typed(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 1'b0);
		add_write(CFG_DECAY_STEP, 24'h7FFFFF);
		add_typed(24'h800000, 24'h800000, 24'hFFFFFF, 1'b0);
		add_item(REQ_STOP, 24'h000000);
		add_typed(24'h7FFFFF, 24'h000000, 24'hFFFFFF, 1'b1);
		add_write(CFG_PEAK_LEVEL, 24'h000000);
		add_item(REQ_NOTE_ON, 24'h000000);
		add_typed(24'h7FFFFF, 24'h000000, 24'h000000, 1'b0);
		add_write(CFG_SPARE_LO, 24'hFFFFFF);
		add_write(CFG_SPARE_HI, 24'h000000);
		add_write(CFG_RELEASE_FLOOR, 24'h000000);
		add_write(CFG_RELEASE_STEP, 24'h7FFFFF);
		add_item(REQ_NOTE_OFF, 24'hFFFFFF);
		add_item(REQ_TICK, 24'h7FFFFF);
		add_item(REQ_TICK, 24'h800000);
		add_item(REQ_TICK, 24'h000001);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < stim_table.size(); i++) begin
			row = stim_table[i];
			if (row.is_write) begin
				settle();
				write_reg(row.reg_idx, row.reg_data);
				cfg_valid <= 1'b0;
			end else begin
				send_item(row.req, row.sample, row.typed, row.want);
			end
		end

		random_start = items_sent;
		while (items_sent - random_start < RandomItems) begin
			settle();
			reconfigure();
			play_phase($urandom_range(30, 120));
		end
		settle();

		$display("covered %0d envelope requests and %0d register writes, %0d tick results checked",
			items_sent, reg_writes, results_seen);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
